// ----- rtl/gsca_pkg.sv -----
// Shared types and constants for the greedy split colour assigner.
`default_nettype none

package gsca_pkg;

   localparam int CMD_W   = 2;
   localparam int BODY_W  = 10;
   localparam int COUNT_W = 11;
   localparam int SPLIT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PAIR   = 2'd0,
      CMD_NONPAR = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WRITE2,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic write2;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_second;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/gsca_ctrl.sv -----
// Sequencer for the greedy split colour assigner: capture, read-modify-write, result hand-off.
`default_nettype none

module gsca_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   input  gsca_pkg::dp_status_type status,
   output gsca_pkg::ctrl_cmd_type  cmd
);

   gsca_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != gsca_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsca_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         gsca_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = gsca_pkg::ST_EXEC;
            end
         end
         gsca_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.need_second) begin
               state_in = gsca_pkg::ST_WRITE2;
            end else if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = gsca_pkg::ST_IDLE;
            end else begin
               state_in = gsca_pkg::ST_HOLD;
            end
         end
         gsca_pkg::ST_WRITE2: begin
            cmd.write2 = 1'b1;
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = gsca_pkg::ST_IDLE;
            end else begin
               state_in = gsca_pkg::ST_HOLD;
            end
         end
         gsca_pkg::ST_HOLD: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = gsca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gsca_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

endmodule

`default_nettype wire

// ----- rtl/gsca_dpath.sv -----
// Datapath: item registers, mask memory, lowest-free split search and result register.
`default_nettype none

module gsca_dpath #(
   parameter int NUM_SPLITS = 32,
   parameter int MAX_BODIES = 1024
) (
   input  wire                              clock,
   input  wire                              reset,
   input  gsca_pkg::ctrl_cmd_type           cmd,
   output gsca_pkg::dp_status_type          status,
   input  wire                              csr_wr_en,
   input  wire [gsca_pkg::COUNT_W-1:0]      csr_wr_data,
   input  wire [gsca_pkg::CMD_W-1:0]        req_cmd,
   input  wire [gsca_pkg::BODY_W-1:0]       req_first_body,
   input  wire                              req_first_active,
   input  wire                              req_first_dynamic,
   input  wire [gsca_pkg::BODY_W-1:0]       req_second_body,
   input  wire                              req_second_active,
   input  wire                              req_second_dynamic,
   output logic [gsca_pkg::SPLIT_W-1:0]     rsp_split_index,
   output logic                             rsp_fault
);

   localparam int AW = $clog2(MAX_BODIES);
   localparam int SW = $clog2(NUM_SPLITS);
   localparam logic [SW-1:0] LAST_SPLIT = SW'(NUM_SPLITS - 1);

   logic [NUM_SPLITS-1:0] mem [MAX_BODIES];

   logic [gsca_pkg::COUNT_W-1:0] count_ff;
   logic [gsca_pkg::CMD_W-1:0]   cmd_ff;
   logic [gsca_pkg::BODY_W-1:0]  b1_ff, b2_ff;
   logic                         a1_ff, d1_ff, a2_ff, d2_ff;
   logic [NUM_SPLITS-1:0]        rd1_ff, rd2_ff;
   logic [gsca_pkg::SPLIT_W-1:0] split_ff;
   logic                         fault_ff;

   logic [AW+gsca_pkg::BODY_W-1:0] ext_r1, ext_r2, ext_b1, ext_b2, ext_bp;
   logic [AW-1:0]                  raddr1, raddr2, addr1, addr2, addrp;

   logic                  u1, u2, r1, r2;
   logic [NUM_SPLITS-1:0] pmask, free_bits, split_bit, wr1_data, wr2_data;
   logic [SW-1:0]         lf_split, split;
   logic                  fault, wr1_ok, need2;
   logic [gsca_pkg::BODY_W-1:0] bp;

   logic                  we;
   logic [AW-1:0]         waddr;
   logic [NUM_SPLITS-1:0] wdata;
   logic [SW+gsca_pkg::SPLIT_W-1:0] split_wide;

   assign ext_r1 = {{AW{1'b0}}, req_first_body};
   assign ext_r2 = {{AW{1'b0}}, req_second_body};
   assign ext_b1 = {{AW{1'b0}}, b1_ff};
   assign ext_b2 = {{AW{1'b0}}, b2_ff};
   assign raddr1 = ext_r1[AW-1:0];
   assign raddr2 = ext_r2[AW-1:0];
   assign addr1  = ext_b1[AW-1:0];
   assign addr2  = ext_b2[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         b1_ff  <= req_first_body;
         a1_ff  <= req_first_active;
         d1_ff  <= req_first_dynamic;
         b2_ff  <= req_second_body;
         a2_ff  <= req_second_active;
         d2_ff  <= req_second_dynamic;
         rd1_ff <= mem[raddr1];
         rd2_ff <= mem[raddr2];
      end
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.load_rsp) begin
         split_ff <= split_wide[gsca_pkg::SPLIT_W-1:0];
         fault_ff <= fault;
      end
   end

   // lowest free split, the last split when all others are taken
   always_comb begin
      free_bits = ~pmask;
      lf_split  = LAST_SPLIT;
      for (int i = NUM_SPLITS - 2; i >= 0; i--) begin
         if (free_bits[i]) begin
            lf_split = SW'(i);
         end
      end
   end

   assign u1 = a1_ff && d1_ff;
   assign u2 = a2_ff && d2_ff;
   assign r1 = ({1'b0, b1_ff} < count_ff) && (32'(b1_ff) < 32'(MAX_BODIES));
   assign r2 = ({1'b0, b2_ff} < count_ff) && (32'(b2_ff) < 32'(MAX_BODIES));

   assign pmask  = (u1 && u2) ? (rd1_ff | rd2_ff) : (u1 ? rd1_ff : rd2_ff);
   assign bp     = u1 ? b1_ff : b2_ff;
   assign ext_bp = {{AW{1'b0}}, bp};
   assign addrp  = ext_bp[AW-1:0];

   always_comb begin
      split     = '0;
      fault     = 1'b0;
      wr1_ok    = 1'b0;
      need2     = 1'b0;
      split_bit = '0;
      wr1_data  = '0;
      wr2_data  = '0;
      case (cmd_ff)
         gsca_pkg::CMD_PAIR: begin
            if (!u1 && !u2) begin
               fault = 1'b1;
            end else if (u1 && u2) begin
               if (!r1 || !r2) begin
                  fault = 1'b1;
               end else begin
                  split     = lf_split;
                  split_bit = NUM_SPLITS'(1) << lf_split;
                  wr1_ok    = 1'b1;
                  need2     = 1'b1;
                  wr1_data  = rd1_ff | split_bit;
                  wr2_data  = rd2_ff | split_bit;
               end
            end else begin
               if (!(u1 ? r1 : r2)) begin
                  fault = 1'b1;
               end else begin
                  split     = lf_split;
                  split_bit = NUM_SPLITS'(1) << lf_split;
                  wr1_ok    = 1'b1;
                  wr1_data  = pmask | split_bit;
               end
            end
         end
         gsca_pkg::CMD_NONPAR: begin
            split = LAST_SPLIT;
            if (a1_ff) begin
               if (!r1) begin
                  fault = 1'b1;
                  split = '0;
               end else begin
                  split_bit = NUM_SPLITS'(1) << LAST_SPLIT;
                  wr1_ok    = 1'b1;
                  wr1_data  = rd1_ff | split_bit;
               end
            end
         end
         gsca_pkg::CMD_CLEAR: begin
            if (!r1) begin
               fault = 1'b1;
            end else begin
               wr1_ok   = 1'b1;
               wr1_data = '0;
            end
         end
         default: begin
            fault = 1'b1;
         end
      endcase
   end

   // pair with one usable body writes that body through the first port slot
   always_comb begin
      we    = 1'b0;
      waddr = addr1;
      wdata = wr1_data;
      if (cmd.exec && wr1_ok) begin
         we    = 1'b1;
         waddr = ((gsca_pkg::cmd_type'(cmd_ff) == gsca_pkg::CMD_PAIR) && !need2) ? addrp : addr1;
         wdata = wr1_data;
      end else if (cmd.write2 && need2) begin
         we    = 1'b1;
         waddr = addr2;
         wdata = wr2_data;
      end
   end

   assign split_wide         = {{gsca_pkg::SPLIT_W{1'b0}}, split};
   assign status.need_second = need2;
   assign rsp_split_index    = split_ff;
   assign rsp_fault          = fault_ff;

endmodule

`default_nettype wire

// ----- rtl/greedy_split_color_assigner.sv -----
// Top level of the greedy split colour assigner.
//
//   port group  direction  handshake            payload
//   req_        in         req_valid/req_stall  cmd, first/second body, active, dynamic
//   rsp_        out        rsp_valid/rsp_stall  split_index, fault
//   csr_        in         csr_wr_en            active_body_count
//
// An item is accepted with its mask reads, then decoded and written; a pair that writes
// both bodies adds the ST_WRITE2 state: the single write port of the mask memory takes the
// second write in its own cycle. The result sits in an output register, so the next
// item is taken while it waits; a stall only holds the sequencer once a second
// result is ready. Reset is synchronous and clears control and the body count; the
// mask memory is not cleared: the user must clear each body by command before use, and the block does not enforce it.
`default_nettype none

module greedy_split_color_assigner #(
   parameter int NUM_SPLITS = 32,
   parameter int MAX_BODIES = 1024
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire [gsca_pkg::CMD_W-1:0]     req_cmd,
   input  wire [gsca_pkg::BODY_W-1:0]    req_first_body,
   input  wire                           req_first_active,
   input  wire                           req_first_dynamic,
   input  wire [gsca_pkg::BODY_W-1:0]    req_second_body,
   input  wire                           req_second_active,
   input  wire                           req_second_dynamic,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [gsca_pkg::SPLIT_W-1:0]  rsp_split_index,
   output logic                          rsp_fault,
   input  wire                           csr_wr_en,
   input  wire [gsca_pkg::COUNT_W-1:0]   csr_wr_data
);

   gsca_pkg::ctrl_cmd_type  cmd;
   gsca_pkg::dp_status_type status;

   gsca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gsca_dpath #(
      .NUM_SPLITS (NUM_SPLITS),
      .MAX_BODIES (MAX_BODIES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_cmd            (req_cmd),
      .req_first_body     (req_first_body),
      .req_first_active   (req_first_active),
      .req_first_dynamic  (req_first_dynamic),
      .req_second_body    (req_second_body),
      .req_second_active  (req_second_active),
      .req_second_dynamic (req_second_dynamic),
      .rsp_split_index    (rsp_split_index),
      .rsp_fault          (rsp_fault)
   );

endmodule

`default_nettype wire

// ----- sim/greedy_split_color_assigner_tb.sv -----
// Self-checking testbench for the greedy split colour assigner.
module greedy_split_color_assigner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SPLITS = 32;
   localparam int MAX_BODIES = 1024;
   localparam logic [gsca_pkg::SPLIT_W-1:0] LAST_SPLIT = gsca_pkg::SPLIT_W'(NUM_SPLITS - 1);
   localparam logic [gsca_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int HOT_N = 6;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [gsca_pkg::CMD_W-1:0]  cmd;
      logic [gsca_pkg::BODY_W-1:0] first_body;
      logic                        first_active;
      logic                        first_dynamic;
      logic [gsca_pkg::BODY_W-1:0] second_body;
      logic                        second_active;
      logic                        second_dynamic;
   } body_request_type;

   typedef struct {
      logic [gsca_pkg::SPLIT_W-1:0] split_index;
      logic                         fault;
   } split_result_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [gsca_pkg::CMD_W-1:0]    req_cmd = '0;
   logic [gsca_pkg::BODY_W-1:0]   req_first_body = '0;
   logic                          req_first_active = 1'b0;
   logic                          req_first_dynamic = 1'b0;
   logic [gsca_pkg::BODY_W-1:0]   req_second_body = '0;
   logic                          req_second_active = 1'b0;
   logic                          req_second_dynamic = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [gsca_pkg::SPLIT_W-1:0]  rsp_split_index;
   logic                          rsp_fault;
   logic                          csr_wr_en = 1'b0;
   logic [gsca_pkg::COUNT_W-1:0]  csr_wr_data = '0;

   body_request_type              request_queue[$];
   split_result_type              expected_splits[$];
   body_request_type              presented;
   logic [NUM_SPLITS-1:0]         used_masks[MAX_BODIES];
   bit                            body_written[MAX_BODIES];
   logic [gsca_pkg::COUNT_W-1:0]  body_count = '0;
   int                            hot_bodies[HOT_N];
   int                            req_accepted = 0;
   int                            result_count = 0;
   int                            mismatch_count = 0;
   int                            hold_cycles = 0;
   bit                            hold_done = 1'b0;
   int                            cycle_count = 0;

   greedy_split_color_assigner i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_first_body     (req_first_body),
      .req_first_active   (req_first_active),
      .req_first_dynamic  (req_first_dynamic),
      .req_second_body    (req_second_body),
      .req_second_active  (req_second_active),
      .req_second_dynamic (req_second_dynamic),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_split_index    (rsp_split_index),
      .rsp_fault          (rsp_fault),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic body_in_range(input logic [gsca_pkg::BODY_W-1:0] body);
      return {1'b0, body} < body_count;
   endfunction

   function automatic logic [gsca_pkg::SPLIT_W-1:0] lowest_free_split(
      input logic [NUM_SPLITS-1:0] used);
      for (int i = 0; i < NUM_SPLITS - 1; i++) begin
         if (!used[i]) begin
            return gsca_pkg::SPLIT_W'(i);
         end
      end
      return LAST_SPLIT;
   endfunction

   // Expected result of one request; updates the mask copy as the block should.
   function automatic split_result_type assign_split(input body_request_type rq);
      split_result_type res;
      logic use1;
      logic use2;
      logic [gsca_pkg::BODY_W-1:0] body;
      logic [gsca_pkg::SPLIT_W-1:0] pick;
      res.split_index = '0;
      res.fault = 1'b0;
      use1 = rq.first_active && rq.first_dynamic;
      use2 = rq.second_active && rq.second_dynamic;
      case (rq.cmd)
         gsca_pkg::CMD_PAIR: begin
            if (!use1 && !use2) begin
               res.fault = 1'b1;
            end else if (use1 && use2) begin
               if (!body_in_range(rq.first_body) || !body_in_range(rq.second_body)) begin
                  res.fault = 1'b1;
               end else begin
                  pick = lowest_free_split(used_masks[rq.first_body] |
                                           used_masks[rq.second_body]);
                  used_masks[rq.first_body][pick] = 1'b1;
                  used_masks[rq.second_body][pick] = 1'b1;
                  res.split_index = pick;
               end
            end else begin
               body = use1 ? rq.first_body : rq.second_body;
               if (!body_in_range(body)) begin
                  res.fault = 1'b1;
               end else begin
                  pick = lowest_free_split(used_masks[body]);
                  used_masks[body][pick] = 1'b1;
                  res.split_index = pick;
               end
            end
         end
         gsca_pkg::CMD_NONPAR: begin
            if (!rq.first_active) begin
               res.split_index = LAST_SPLIT;
            end else if (!body_in_range(rq.first_body)) begin
               res.fault = 1'b1;
            end else begin
               used_masks[rq.first_body][LAST_SPLIT] = 1'b1;
               res.split_index = LAST_SPLIT;
            end
         end
         gsca_pkg::CMD_CLEAR: begin
            if (!body_in_range(rq.first_body)) begin
               res.fault = 1'b1;
            end else begin
               used_masks[rq.first_body] = '0;
            end
         end
         default: begin
            res.fault = 1'b1;
         end
      endcase
      return res;
   endfunction

   function automatic body_request_type make_req(
      input logic [gsca_pkg::CMD_W-1:0] cmd,
      input int b1, input logic a1, input logic d1,
      input int b2, input logic a2, input logic d2);
      body_request_type rq;
      rq.cmd = cmd;
      rq.first_body = gsca_pkg::BODY_W'(b1);
      rq.first_active = a1;
      rq.first_dynamic = d1;
      rq.second_body = gsca_pkg::BODY_W'(b2);
      rq.second_active = a2;
      rq.second_dynamic = d2;
      return rq;
   endfunction

   // A mask is only read once written: clear it first if needed.
   function automatic void prepare_body(input logic [gsca_pkg::BODY_W-1:0] body);
      if (!body_written[body]) begin
         request_queue.push_back(make_req(gsca_pkg::CMD_CLEAR, int'(body),
                                          1'($urandom_range(1)), 1'($urandom_range(1)),
                                          $urandom_range(1023), 1'($urandom_range(1)),
                                          1'($urandom_range(1))));
         body_written[body] = 1'b1;
      end
   endfunction

   function automatic void queue_request(input body_request_type rq);
      logic use1;
      logic use2;
      use1 = rq.first_active && rq.first_dynamic;
      use2 = rq.second_active && rq.second_dynamic;
      if (rq.cmd == gsca_pkg::CMD_PAIR) begin
         if (use1 && use2) begin
            if (body_in_range(rq.first_body) && body_in_range(rq.second_body)) begin
               prepare_body(rq.first_body);
               prepare_body(rq.second_body);
            end
         end else if (use1 && body_in_range(rq.first_body)) begin
            prepare_body(rq.first_body);
         end else if (use2 && body_in_range(rq.second_body)) begin
            prepare_body(rq.second_body);
         end
      end else if (rq.cmd == gsca_pkg::CMD_NONPAR) begin
         if (rq.first_active && body_in_range(rq.first_body)) begin
            prepare_body(rq.first_body);
         end
      end else if (rq.cmd == gsca_pkg::CMD_CLEAR && body_in_range(rq.first_body)) begin
         body_written[rq.first_body] = 1'b1;
      end
      request_queue.push_back(rq);
   endfunction

   function automatic void pick_hot_bodies();
      for (int i = 0; i < HOT_N; i++) begin
         if (body_count == 0) begin
            hot_bodies[i] = $urandom_range(MAX_BODIES - 1);
         end else if (i == 0) begin
            hot_bodies[i] = 0;
         end else if (i == 1) begin
            hot_bodies[i] = body_count - 1;
         end else begin
            hot_bodies[i] = $urandom_range(body_count - 1);
         end
      end
   endfunction

   // Mostly pair assigns on a few hot bodies so masks fill up to the last split.
   function automatic body_request_type random_request();
      body_request_type rq;
      int r;
      r = $urandom_range(99);
      rq = make_req(gsca_pkg::CMD_PAIR, hot_bodies[$urandom_range(HOT_N - 1)], 1'b1, 1'b1,
                    hot_bodies[$urandom_range(HOT_N - 1)], 1'b1, 1'b1);
      if (r < 55) begin
         if ($urandom_range(9) == 0) begin
            rq.second_body = gsca_pkg::BODY_W'($urandom_range(1023));
         end
      end else if (r < 65) begin
         if ($urandom_range(1)) begin
            {rq.first_active, rq.first_dynamic} = 2'($urandom_range(2));
            rq.first_body = gsca_pkg::BODY_W'($urandom_range(1023));
         end else begin
            {rq.second_active, rq.second_dynamic} = 2'($urandom_range(2));
            rq.second_body = gsca_pkg::BODY_W'($urandom_range(1023));
         end
      end else if (r < 70) begin
         {rq.first_active, rq.first_dynamic} = 2'($urandom_range(2));
         {rq.second_active, rq.second_dynamic} = 2'($urandom_range(2));
         rq.first_body = gsca_pkg::BODY_W'($urandom_range(1023));
         rq.second_body = gsca_pkg::BODY_W'($urandom_range(1023));
      end else if (r < 80) begin
         rq.cmd = gsca_pkg::CMD_NONPAR;
         rq.first_active = 1'($urandom_range(1));
         rq.first_dynamic = 1'($urandom_range(1));
         rq.second_body = gsca_pkg::BODY_W'($urandom_range(1023));
      end else if (r < 85) begin
         rq.cmd = gsca_pkg::CMD_CLEAR;
         rq.first_active = 1'($urandom_range(1));
         rq.second_dynamic = 1'($urandom_range(1));
      end else begin
         rq = make_req(r < 88 ? CMD_UNKNOWN : gsca_pkg::CMD_W'($urandom_range(3)),
                       $urandom_range(1023), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       $urandom_range(1023), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      return rq;
   endfunction

   function automatic void queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         queue_request(random_request());
      end
   endfunction

   task automatic drain_requests();
      while (request_queue.size() != 0 || req_valid || expected_splits.size() != 0) begin
         @(posedge clock);
      end
      repeat (5) @(posedge clock);
   endtask

   task automatic write_body_count(input logic [gsca_pkg::COUNT_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      body_count = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pick_hot_bodies();
   endtask

   // Sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_splits.push_back(assign_split(presented));
            req_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (request_queue.size() != 0 &&
                !($urandom_range(99) < 9 && !(req_accepted >= 900 && req_accepted < 1200))) begin
               presented = request_queue.pop_front();
               req_valid <= 1'b1;
               req_cmd <= presented.cmd;
               req_first_body <= presented.first_body;
               req_first_active <= presented.first_active;
               req_first_dynamic <= presented.first_dynamic;
               req_second_body <= presented.second_body;
               req_second_active <= presented.second_active;
               req_second_dynamic <= presented.second_dynamic;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver
   always @(posedge clock) begin
      split_result_type exp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_splits.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, actual split %0d fault %0b",
                        $time, rsp_split_index, rsp_fault);
            end else begin
               exp = expected_splits.pop_front();
               if (rsp_split_index !== exp.split_index) begin
                  mismatch_count++;
                  $display("%0t: split_index mismatch, expected %0d, actual %0d",
                           $time, exp.split_index, rsp_split_index);
               end
               if (rsp_fault !== exp.fault) begin
                  mismatch_count++;
                  $display("%0t: fault mismatch, expected %0b, actual %0b",
                           $time, exp.fault, rsp_fault);
               end
            end
         end
         // long hold-off so the block backs up and stalls its input
         if (result_count >= 200 && !hold_done) begin
            hold_done = 1'b1;
            hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= $urandom_range(99) < 9 && !(result_count >= 900 && result_count < 1200);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("greedy_split_color_assigner test failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_body_count(11'd1024);
      queue_request(make_req(gsca_pkg::CMD_CLEAR, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0));
      queue_request(make_req(gsca_pkg::CMD_CLEAR, 1023, 1'b1, 1'b1, 1023, 1'b1, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_CLEAR, 512, 1'b0, 1'b1, 0, 1'b1, 1'b0));
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b1, 1'b1, 1023, 1'b1, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b1, 1'b1, 1023, 1'b1, 1'b1));
      // only one body of the pair usable, then neither usable
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b1, 1'b1, 1023, 1'b1, 1'b0));
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b0, 1'b1, 1023, 1'b1, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b1, 1'b0, 1023, 1'b0, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_NONPAR, 0, 1'b1, 1'b0, 0, 1'b0, 1'b0));
      queue_request(make_req(gsca_pkg::CMD_NONPAR, 1023, 1'b0, 1'b1, 1023, 1'b1, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b1, 1'b1, 0, 1'b1, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_CLEAR, 0, 1'b1, 1'b1, 1023, 1'b1, 1'b1));
      queue_request(make_req(CMD_UNKNOWN, 1023, 1'b1, 1'b1, 1023, 1'b1, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_PAIR, 512, 1'b1, 1'b1, 512, 1'b1, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b1, 1'b1, 512, 1'b1, 1'b1));
      queue_random(350);
      drain_requests();
      queue_random(350);
      drain_requests();

      // nothing in range
      write_body_count(11'd0);
      queue_request(make_req(gsca_pkg::CMD_CLEAR, 0, 1'b1, 1'b1, 0, 1'b0, 1'b0));
      queue_request(make_req(gsca_pkg::CMD_NONPAR, 0, 1'b1, 1'b1, 0, 1'b0, 1'b0));
      queue_random(60);
      drain_requests();

      write_body_count(11'd1);
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b1, 1'b1, 1, 1'b1, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b1, 1'b1, 1, 1'b0, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_PAIR, 0, 1'b1, 1'b0, 1, 1'b1, 1'b1));
      queue_request(make_req(gsca_pkg::CMD_CLEAR, 1, 1'b0, 1'b0, 0, 1'b0, 1'b0));
      queue_request(make_req(gsca_pkg::CMD_NONPAR, 1, 1'b1, 1'b1, 0, 1'b0, 1'b0));
      queue_request(make_req(gsca_pkg::CMD_NONPAR, 1, 1'b0, 1'b0, 0, 1'b0, 1'b0));
      queue_request(make_req(gsca_pkg::CMD_CLEAR, 0, 1'b1, 1'b0, 0, 1'b1, 1'b0));
      queue_random(150);
      drain_requests();

      write_body_count(11'd1023);
      queue_random(250);
      drain_requests();

      write_body_count(gsca_pkg::COUNT_W'($urandom_range(1022, 2)));
      queue_random(250);
      drain_requests();

      write_body_count(11'd1024);
      queue_random(200);
      drain_requests();

      repeat (15) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("greedy_split_color_assigner test passed");
      end else begin
         $display("greedy_split_color_assigner test failed");
      end
      $finish;
   end

endmodule
